>>> hdl/stepper_carousel_indexer_top_assert.svh
// Assertion macros used by the checker file.
`ifndef STEPPER_CAROUSEL_INDEXER_TOP_ASSERT_SVH
`define STEPPER_CAROUSEL_INDEXER_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define STCI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define STCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/stci_pkg.sv
`timescale 1ns / 1ps
package stci_pkg;

    // request kinds on s_tuser
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_GOTO = 2'd1;
    localparam logic [1:0] REQ_CAL  = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SPR = 2'd0;
    localparam logic [1:0] REG_NC  = 2'd1;
    localparam logic [1:0] REG_SI  = 2'd2;

    localparam logic [15:0] SPR_RESET = 16'd2048;
    localparam logic [5:0]  NC_RESET  = 6'd8;
    localparam logic [19:0] SI_RESET  = 20'd2000;

    localparam int POS_W  = 16;
    localparam int IDX_W  = 8;
    localparam int CIDX_W = 5;
    localparam int TICK_W = 20;
    // dividend holds 2*idx*rev + nc, idx < 256, rev < 2^16
    localparam int DVD_W  = 25;
    localparam int DSR_W  = 16;
    localparam int CNT_W  = $clog2(DVD_W);

    localparam logic [3:0] PHASE_PAT [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

    typedef struct packed {
        logic [15:0] spr;
        logic [5:0]  nc;
        logic [19:0] si;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic posr_load;
        logic tick_inc;
        logic mod_start;
        logic mod_load;
        logic tgt_start;
        logic tgt_load;
        logic aim;
        logic set_move;
        logic step;
        logic calibrate;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       moving;
        logic       tick_reached;
        logic       pos_oor;
        logic       goto_ok;
        logic       div_done;
    } status_t;

endpackage

>>> hdl/stci_regs.sv
`timescale 1ns / 1ps
module stci_regs
    import stci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [15:0] spr_reg, spr_next;
    logic [5:0]  nc_reg, nc_next;
    logic [19:0] si_reg, si_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        spr_next = spr_reg;
        nc_next  = nc_reg;
        si_next  = si_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_SPR: spr_next = pwdata[15:0];
                REG_NC:  nc_next  = pwdata[5:0];
                REG_SI:  si_next  = pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg <= SPR_RESET;
            nc_reg  <= NC_RESET;
            si_reg  <= SI_RESET;
        end
        else
        begin
            spr_reg <= spr_next;
            nc_reg  <= nc_next;
            si_reg  <= si_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SPR: prdata = {16'd0, spr_reg};
            REG_NC:  prdata = {26'd0, nc_reg};
            REG_SI:  prdata = {12'd0, si_reg};
            default: prdata = 32'd0;
        endcase
    end

    assign cfg = '{spr: spr_reg, nc: nc_reg, si: si_reg};

endmodule

>>> hdl/stci_div.sv
`timescale 1ns / 1ps
module stci_div
    import stci_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quot,
    output logic [DSR_W-1:0] rem
);

    // restoring divider, one quotient bit per cycle
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   shifted;
    logic [DSR_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(DVD_W - 1);
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;

endmodule

>>> hdl/stci_dp.sv
`timescale 1ns / 1ps
module stci_dp
    import stci_pkg::*;
#(
    parameter int MAX_COMPARTMENTS = 32,
    parameter int STEP_BITS        = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    output logic [31:0] m_tdata,
    output logic [0:0]  m_tuser
);

    localparam logic [32:0] REV_LIM = 33'(1) << STEP_BITS;
    localparam logic [8:0]  MAX_C   = 9'(MAX_COMPARTMENTS);

    // architectural state
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  sl_reg, sl_next;
    logic              rdir_reg, rdir_next;
    logic [1:0]        phase_reg, phase_next;
    logic              moving_reg, moving_next;
    logic [TICK_W-1:0] tc_reg, tc_next;
    logic [CIDX_W-1:0] cidx_reg, cidx_next;
    logic              cal_reg, cal_next;
    logic              coils_reg, coils_next;
    logic              save_reg, save_next;

    // per-item working registers
    logic [1:0]        req_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [23:0]       prod_reg;
    logic [POS_W-1:0]  posr_reg;
    logic [POS_W-1:0]  tgt_reg;
    logic [POS_W-1:0]  d_reg;
    logic [31:0]       out_data_reg;
    logic              out_user_reg;

    logic [POS_W-1:0]  rev;
    logic [TICK_W-1:0] iv;
    logic [TICK_W:0]   tc_inc;
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DSR_W-1:0]  div_dsr;
    logic              div_done;
    logic [DVD_W-1:0]  div_quot;
    logic [DSR_W-1:0]  div_rem;
    logic [16:0]       q17;
    logic [16:0]       tgt_red;
    logic [POS_W-1:0]  d_calc;
    logic [POS_W-1:0]  half_rev;
    logic [16:0]       pos_fwd;
    logic [POS_W-1:0]  step_pos;
    logic [1:0]        step_phase;
    logic [POS_W-1:0]  sl_dec;
    logic [3:0]        coil_out;

    // effective revolution: at least 2, at most 2^STEP_BITS
    always_comb
    begin
        if (cfg.spr < 16'd2)
            rev = 16'd2;
        else if ({17'd0, cfg.spr} > REV_LIM)
            rev = REV_LIM[POS_W-1:0];
        else
            rev = cfg.spr;
    end

    assign iv     = (cfg.si == '0) ? TICK_W'(1) : cfg.si;
    assign tc_inc = {1'b0, tc_reg} + 1'b1;

    assign st.kind         = req_reg;
    assign st.moving       = moving_reg;
    assign st.tick_reached = tc_inc >= {1'b0, iv};
    assign st.pos_oor      = pos_reg >= rev;
    assign st.goto_ok      = ({1'b0, idx_reg} < MAX_C) && (idx_reg < {2'd0, cfg.nc});
    assign st.div_done     = div_done;

    // one shared divider: position modulo revolution, or the rounded target
    assign div_start = cmd.mod_start | cmd.tgt_start;
    assign div_dvd   = cmd.mod_start ? DVD_W'(pos_reg)
                                     : ({prod_reg, 1'b0} + DVD_W'(cfg.nc));
    assign div_dsr   = cmd.mod_start ? rev : DSR_W'({cfg.nc, 1'b0});

    stci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // rounded target never exceeds rev, so one subtract wraps it
    assign q17     = div_quot[16:0];
    assign tgt_red = (q17 >= {1'b0, rev}) ? (q17 - {1'b0, rev}) : q17;

    assign d_calc   = (tgt_reg >= posr_reg) ? (tgt_reg - posr_reg)
                                            : (tgt_reg + (rev - posr_reg));
    assign half_rev = rev >> 1;

    assign pos_fwd    = {1'b0, posr_reg} + 1'b1;
    assign step_pos   = rdir_reg ? ((posr_reg == '0) ? (rev - 1'b1) : (posr_reg - 1'b1))
                                 : ((pos_fwd == {1'b0, rev}) ? '0 : pos_fwd[POS_W-1:0]);
    assign step_phase = rdir_reg ? (phase_reg - 1'b1) : (phase_reg + 1'b1);
    assign sl_dec     = sl_reg - 1'b1;

    always_comb
    begin
        pos_next    = pos_reg;
        sl_next     = sl_reg;
        rdir_next   = rdir_reg;
        phase_next  = phase_reg;
        moving_next = moving_reg;
        tc_next     = tc_reg;
        cidx_next   = cidx_reg;
        cal_next    = cal_reg;
        coils_next  = coils_reg;
        save_next   = save_reg;
        if (cmd.load)
            save_next = 1'b0;
        if (cmd.tick_inc)
            tc_next = tc_inc[TICK_W-1:0];
        if (cmd.set_move)
        begin
            if (d_reg > half_rev)
            begin
                rdir_next = 1'b1;
                sl_next   = rev - d_reg;
            end
            else
            begin
                rdir_next = 1'b0;
                sl_next   = d_reg;
            end
            cidx_next   = idx_reg[CIDX_W-1:0];
            cal_next    = 1'b1;
            moving_next = d_reg != '0;
            tc_next     = '0;
        end
        if (cmd.step)
        begin
            tc_next    = '0;
            pos_next   = step_pos;
            phase_next = step_phase;
            coils_next = 1'b1;
            sl_next    = sl_dec;
            if (sl_dec == '0)
            begin
                moving_next = 1'b0;
                coils_next  = 1'b0;
                save_next   = 1'b1;
            end
        end
        if (cmd.calibrate)
        begin
            pos_next    = '0;
            cidx_next   = '0;
            cal_next    = 1'b1;
            moving_next = 1'b0;
            sl_next     = '0;
            coils_next  = 1'b0;
            save_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sl_reg     <= '0;
            rdir_reg   <= 1'b0;
            phase_reg  <= '0;
            moving_reg <= 1'b0;
            tc_reg     <= '0;
            cidx_reg   <= '0;
            cal_reg    <= 1'b0;
            coils_reg  <= 1'b0;
            save_reg   <= 1'b0;
            req_reg    <= REQ_TICK;
        end
        else
        begin
            pos_reg    <= pos_next;
            sl_reg     <= sl_next;
            rdir_reg   <= rdir_next;
            phase_reg  <= phase_next;
            moving_reg <= moving_next;
            tc_reg     <= tc_next;
            cidx_reg   <= cidx_next;
            cal_reg    <= cal_next;
            coils_reg  <= coils_next;
            save_reg   <= save_next;
            if (cmd.load)
                req_reg <= s_tuser;
        end
    end

    assign coil_out = coils_reg ? PHASE_PAT[phase_reg] : 4'h0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            idx_reg <= s_tdata;
        prod_reg <= 24'(idx_reg) * 24'(rev);
        if (cmd.posr_load)
            posr_reg <= pos_reg;
        else if (cmd.mod_load)
            posr_reg <= div_rem;
        if (cmd.tgt_load)
            tgt_reg <= tgt_red[POS_W-1:0];
        if (cmd.aim)
            d_reg <= d_calc;
        if (cmd.out_load)
        begin
            out_data_reg <= {save_reg ? cidx_reg : 5'd0,
                             pos_reg,
                             cal_reg ? cidx_reg : 5'd0,
                             cal_reg,
                             moving_reg,
                             coil_out};
            out_user_reg <= save_reg;
        end
    end

    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

endmodule

>>> hdl/stci_ctrl.sv
`timescale 1ns / 1ps
module stci_ctrl
    import stci_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_MOD    = 9'b000000100,
        S_TGT_GO = 9'b000001000,
        S_TGT    = 9'b000010000,
        S_AIM    = 9'b000100000,
        S_SET    = 9'b001000000,
        S_STEP   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   out_free;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = mvalid_reg;
    assign out_free = !mvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.posr_load = 1'b1;
                case (st.kind)
                    REQ_TICK:
                    begin
                        if (!st.moving)
                            state_next = S_OUT;
                        else if (!st.tick_reached)
                        begin
                            cmd.tick_inc = 1'b1;
                            state_next   = S_OUT;
                        end
                        else if (st.pos_oor)
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_MOD;
                        end
                        else
                            state_next = S_STEP;
                    end
                    REQ_GOTO:
                    begin
                        if (!st.goto_ok)
                            state_next = S_OUT;
                        else if (st.pos_oor)
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_MOD;
                        end
                        else
                            state_next = S_TGT_GO;
                    end
                    REQ_CAL:
                    begin
                        cmd.calibrate = 1'b1;
                        state_next    = S_OUT;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_MOD:
            begin
                if (st.div_done)
                begin
                    cmd.mod_load = 1'b1;
                    state_next   = (st.kind == REQ_GOTO) ? S_TGT_GO : S_STEP;
                end
            end
            S_TGT_GO:
            begin
                cmd.tgt_start = 1'b1;
                state_next    = S_TGT;
            end
            S_TGT:
            begin
                if (st.div_done)
                begin
                    cmd.tgt_load = 1'b1;
                    state_next   = S_AIM;
                end
            end
            S_AIM:
            begin
                cmd.aim    = 1'b1;
                state_next = S_SET;
            end
            S_SET:
            begin
                cmd.set_move = 1'b1;
                state_next   = S_OUT;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            mvalid_next = 1'b1;
        else if (m_tready)
            mvalid_next = 1'b0;
        else
            mvalid_next = mvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

>>> hdl/stepper_carousel_indexer_top.sv
`timescale 1ns / 1ps
// Full-step position indexer for a four-coil unipolar stepper turning a carousel of
// evenly spaced compartments. Each input beat gives exactly one status beat out. A goto
// to an accepted compartment runs the shared restoring divider, which rounds the
// compartment to a step; a goto or a firing tick whose stored position lies outside the
// current revolution runs that divider once more first. A new beat is taken while the
// previous result still waits on m_tready. Reset leaves the block uncalibrated with coils
// off, and the registers at 2048 steps per revolution, 8 compartments, 2000 ticks per
// step.
module stepper_carousel_indexer_top
    import stci_pkg::*;
#(
    parameter int MAX_COMPARTMENTS = 32,
    parameter int STEP_BITS        = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] target_index
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] coil_drive, [4] is_moving, [5] is_calibrated, [10:6] shown_index,
    // [26:11] position_step, [31:27] save_index
    output logic [31:0] m_tdata,
    output logic [0:0]  m_tuser,   // [0] save_strobe
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t st;

    stci_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    stci_dp #(
        .MAX_COMPARTMENTS (MAX_COMPARTMENTS),
        .STEP_BITS        (STEP_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cmd     (cmd),
        .st      (st),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

>>> hdl/stci_checker.sv
`timescale 1ns / 1ps
`include "stepper_carousel_indexer_top_assert.svh"
module stci_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result beat holds
    `STCI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // a save only happens once motion has stopped
    `STCI_ASSERT_SAME(a_save_idle, m_tvalid && m_tuser[0], !m_tdata[4], "save strobed during a move")

    // uncalibrated: no index shown, nothing saved, coils off
    `STCI_ASSERT_SAME(a_uncal_quiet, m_tvalid && !m_tdata[5], (m_tdata[10:6] == 5'd0) && !m_tuser[0] && (m_tdata[3:0] == 4'h0), "activity while uncalibrated")

    // energized coils show one of the four full-step phases
    `STCI_ASSERT_SAME(a_coil_phase, m_tvalid && (m_tdata[3:0] != 4'h0), (m_tdata[3:0] == 4'h3) || (m_tdata[3:0] == 4'h6) || (m_tdata[3:0] == 4'hC) || (m_tdata[3:0] == 4'h9), "illegal coil pattern")

endmodule

bind stepper_carousel_indexer_top stci_checker u_stci_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/tb_stepper_carousel_indexer_top.sv
`timescale 1ns / 1ps
module tb_stepper_carousel_indexer_top;
    import stci_pkg::*;

    localparam int MAX_COMPARTMENTS = 32;
    localparam int STEP_BITS        = 16;
    localparam logic [1:0] REQ_NONE = 2'd3;   // unused code, reports status only
    localparam int HOLD_AT     = 60;
    localparam int HOLD_SPAN   = 300;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] idx;
    } carousel_req_t;

    typedef struct packed {
        logic [3:0]  coil_drive;
        logic        is_moving;
        logic        is_calibrated;
        logic [4:0]  shown_index;
        logic [15:0] position_step;
        logic        save_strobe;
        logic [4:0]  save_index;
    } carousel_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    stepper_carousel_indexer_top #(
        .MAX_COMPARTMENTS(MAX_COMPARTMENTS),
        .STEP_BITS(STEP_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    carousel_req_t  req_backlog[$];
    carousel_beat_t status_due[$];
    int snd_idle_pct = 14;
    int rcv_idle_pct = 46;
    int n_bad = 0;
    int beats_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    // shadow of the block: registers and motion state
    logic [15:0] spr_q = SPR_RESET;
    logic [5:0]  nc_q  = NC_RESET;
    logic [19:0] si_q  = SI_RESET;
    longint unsigned pos_m = 0, left_m = 0, ticks_m = 0;
    logic [1:0] phase_m = 2'd0;
    logic [4:0] cidx_m = 5'd0;
    logic reverse_m = 1'b0, moving_m = 1'b0, cal_m = 1'b0, energized_m = 1'b0;

    task automatic carousel_predict(input logic [1:0] req, input logic [7:0] idx);
        longint unsigned rev, nc, tgt, pos, d, iv;
        carousel_beat_t b;
        logic save;
        save = 1'b0;
        rev = (spr_q < 16'd2) ? 2 : spr_q;
        case (req)
            REQ_TICK:
            begin
                if (moving_m)
                begin
                    iv = (si_q == 20'd0) ? 1 : si_q;
                    ticks_m++;
                    if (ticks_m >= iv)
                    begin
                        ticks_m = 0;
                        pos = pos_m % rev;
                        if (reverse_m)
                        begin
                            phase_m = phase_m - 2'd1;
                            pos = (pos == 0) ? rev - 1 : pos - 1;
                        end
                        else
                        begin
                            phase_m = phase_m + 2'd1;
                            pos = (pos + 1) % rev;
                        end
                        pos_m = pos;
                        energized_m = 1'b1;
                        left_m--;
                        if (left_m == 0)
                        begin
                            moving_m = 1'b0;
                            energized_m = 1'b0;
                            save = 1'b1;
                        end
                    end
                end
            end
            REQ_GOTO:
            begin
                nc = nc_q;
                if (idx < nc && idx < MAX_COMPARTMENTS)
                begin
                    // rounded to nearest, halves up
                    tgt = ((2 * longint'(idx) * rev + nc) / (2 * nc)) % rev;
                    pos = pos_m % rev;
                    d = (tgt + rev - pos) % rev;
                    if (d > rev / 2)
                    begin
                        reverse_m = 1'b1;
                        left_m = rev - d;
                    end
                    else
                    begin
                        reverse_m = 1'b0;
                        left_m = d;
                    end
                    cidx_m = idx[4:0];
                    cal_m = 1'b1;
                    moving_m = (left_m != 0);
                    ticks_m = 0;
                end
            end
            REQ_CAL:
            begin
                pos_m = 0;
                cidx_m = 5'd0;
                cal_m = 1'b1;
                moving_m = 1'b0;
                left_m = 0;
                energized_m = 1'b0;
                save = 1'b1;
            end
            default:
            begin
            end
        endcase
        b.coil_drive    = energized_m ? PHASE_PAT[phase_m] : 4'h0;
        b.is_moving     = moving_m;
        b.is_calibrated = cal_m;
        b.shown_index   = cal_m ? cidx_m : 5'd0;
        b.position_step = pos_m[15:0];
        b.save_strobe   = save;
        b.save_index    = save ? cidx_m : 5'd0;
        status_due.push_back(b);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_bad++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin : drive_requests
        carousel_req_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                carousel_predict(s_tuser, s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    nxt = req_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.req;
                    s_tdata  <= nxt.idx;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // status monitor, with one long hold-off to back the block up
    always @(posedge clk)
    begin : watch_status
        carousel_beat_t want, got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.coil_drive    = m_tdata[3:0];
                got.is_moving     = m_tdata[4];
                got.is_calibrated = m_tdata[5];
                got.shown_index   = m_tdata[10:6];
                got.position_step = m_tdata[26:11];
                got.save_index    = m_tdata[31:27];
                got.save_strobe   = m_tuser[0];
                beats_seen <= beats_seen + 1;
                if (status_due.size() == 0)
                begin
                    $error("status beat with nothing expected");
                    n_bad++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("coil_drive", want.coil_drive, got.coil_drive);
                    check_field("is_moving", want.is_moving, got.is_moving);
                    check_field("is_calibrated", want.is_calibrated, got.is_calibrated);
                    check_field("shown_index", want.shown_index, got.shown_index);
                    check_field("position_step", want.position_step, got.position_step);
                    check_field("save_strobe", want.save_strobe, got.save_strobe);
                    check_field("save_index", want.save_index, got.save_index);
                end
            end
            if (!hold_done && beats_seen == HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_SPAN;
                m_tready  <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("stepper_carousel_indexer_top test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_req(input logic [1:0] req, input logic [7:0] idx);
        carousel_req_t r;
        r.req = req;
        r.idx = idx;
        req_backlog.push_back(r);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_req(REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    // sampled on the falling edge so the driver's last offer has settled
    task automatic wait_drained();
        while (req_backlog.size() != 0 || s_tvalid || status_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] which, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            REG_SPR: spr_q = value[15:0];
            REG_NC:  nc_q  = value[5:0];
            REG_SI:  si_q  = value[19:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_geometry(input logic [15:0] spr, input logic [5:0] nc,
                                input logic [19:0] si);
        write_reg(REG_SPR, {16'd0, spr});
        write_reg(REG_NC, {26'd0, nc});
        write_reg(REG_SI, {12'd0, si});
    endtask

    // goto followed by a burst of ticks, mixed with calibrates and stray codes
    task automatic queue_random(input int n);
        int left;
        int r;
        int burst;
        logic [7:0] idx;
        left = n;
        while (left > 0)
        begin
            r = $urandom_range(99);
            if (r < 18)
            begin
                idx = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 40));
                burst = $urandom_range(2, 12);
                push_req(REQ_GOTO, idx);
                push_ticks(burst);
                left -= 1 + burst;
            end
            else
            begin
                if (r < 22)
                    push_req(REQ_CAL, 8'($urandom_range(0, 255)));
                else if (r < 25)
                    push_req(REQ_NONE, 8'($urandom_range(0, 255)));
                else
                    push_req(REQ_TICK, 8'($urandom_range(0, 255)));
                left--;
            end
        end
    endtask

    task automatic run_phase(input logic [15:0] spr, input logic [5:0] nc,
                             input logic [19:0] si, input int snd, input int rcv);
        wait_drained();
        set_geometry(spr, nc, si);
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
        queue_random(103);
        wait_drained();
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: 2048 steps, 8 compartments, 2000 ticks per step
        push_req(REQ_TICK, 8'hFF);      // idle and uncalibrated
        push_req(REQ_NONE, 8'hFF);
        push_req(REQ_GOTO, 8'd8);       // not below compartment count
        push_req(REQ_GOTO, 8'd255);
        push_req(REQ_GOTO, 8'd0);       // zero-length, sets calibrated
        push_req(REQ_GOTO, 8'd4);       // exactly half a turn goes forward
        push_ticks(3);
        push_req(REQ_GOTO, 8'd7);       // retarget mid-move, goes reverse
        push_req(REQ_TICK, 8'h00);
        push_req(REQ_CAL, 8'h00);       // calibrate cancels the move
        wait_drained();

        // 10 steps, 4 compartments: targets 0, 3, 5, 8
        set_geometry(16'd10, 6'd4, 20'd1);
        push_req(REQ_GOTO, 8'd3);       // reverse through the zero crossing
        push_ticks(2);
        push_req(REQ_GOTO, 8'd3);       // zero-length with coils off
        push_req(REQ_GOTO, 8'd1);
        push_ticks(3);
        push_req(REQ_GOTO, 8'd2);
        push_ticks(2);
        push_req(REQ_GOTO, 8'd1);       // zero-length with coils energized
        push_req(REQ_TICK, 8'h5A);
        wait_drained();

        run_phase(16'd12, 6'd5, 20'd1, 14, 46);
        run_phase(16'd0, 6'd1, 20'd0, 14, 46);        // revolution clamps to 2, interval to 1
        run_phase(16'd1, 6'd63, 20'd2, 14, 46);       // indexes past 31 are dropped
        run_phase(16'd2048, 6'd32, 20'd1, 46, 14);
        run_phase(16'd65535, 6'd32, 20'd1, 46, 14);
        run_phase(16'd7, 6'd0, 20'd3, 46, 14);        // position left beyond the turn
        run_phase(16'd100, 6'd9, 20'hFFFFF, 0, 0);
        run_phase(16'd37, 6'd31, 20'd2, 0, 0);
        run_phase(16'd16, 6'd16, 20'd1, 0, 0);

        wait_drained();
        repeat (60) @(posedge clk);
        if (n_bad == 0 && status_due.size() == 0)
            $display("stepper_carousel_indexer_top test passed");
        else
            $display("stepper_carousel_indexer_top test failed");
        $finish;
    end

endmodule
